FILE: src/lcdpi_pkg.sv
// Shared types, constants and the init command table of the display power-on sequencer.
`default_nettype none
package lcdpi_pkg;

	localparam int NUM_INIT_COMMANDS = 5;
	localparam int MAX_PARAM_BYTES   = 4;
	localparam int TABLE_SLOTS       = 16;
	localparam int ARG_SLOTS         = 4;
	localparam int QUEUE_DEPTH       = 4;

	localparam int ENTRY_W   = $clog2(TABLE_SLOTS);
	localparam int CMD_IDX_W = $clog2(NUM_INIT_COMMANDS + 1);
	localparam int POS_W     = $clog2(MAX_PARAM_BYTES + 1);
	localparam int ARG_IDX_W = $clog2(ARG_SLOTS);
	localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_IDLE  = 2'd1;
	localparam logic [1:0] STATUS_FAULT = 2'd2;

	localparam logic CFG_RESET_LOW     = 1'b0;
	localparam logic CFG_RESET_RECOVER = 1'b1;

	localparam logic [15:0] RESET_LOW_DEFAULT     = 16'd10;
	localparam logic [15:0] RESET_RECOVER_DEFAULT = 16'd120;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_HIGH = 3'd2,
		PH_CMDS     = 3'd3,
		PH_READY    = 3'd4,
		PH_ERROR    = 3'd5
	} phase_t;

	typedef struct packed {
		logic        action;
		logic [31:0] now_ms;
		logic        bus_fault;
	} in_item_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       is_data;
		logic       reset_level;
		logic       ready_flag;
		logic [1:0] step_status;
		logic       last_of_run;
	} out_item_t;

	// one decoded step handed from the front to the back
	typedef struct packed {
		logic               has_entry;
		logic [ENTRY_W-1:0] entry;
		logic [1:0]         status;
		logic               reset_level;
		logic               ready_flag;
	} job_t;

	typedef struct packed {
		logic [15:0] reset_low_ms;
		logic [15:0] reset_recover_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0]                op;
		logic [ARG_SLOTS-1:0][7:0] args;
		logic [2:0]                nargs;
		logic [15:0]               wait_ms;
	} seq_entry_t;

	function automatic seq_entry_t seq_entry(input logic [ENTRY_W-1:0] idx);
		seq_entry_t e;
		e = '0;
		case (idx)
			ENTRY_W'(0): begin
				e.op = 8'h01; e.wait_ms = 16'd120;
			end
			ENTRY_W'(1): begin
				e.op = 8'h11; e.wait_ms = 16'd120;
			end
			ENTRY_W'(2): begin
				e.op = 8'h3A; e.args[0] = 8'h55; e.nargs = 3'd1; e.wait_ms = 16'd10;
			end
			ENTRY_W'(3): begin
				e.op = 8'h36; e.args[0] = 8'h48; e.nargs = 3'd1; e.wait_ms = 16'd10;
			end
			ENTRY_W'(4): begin
				e.op = 8'h29; e.wait_ms = 16'd20;
			end
			default: e = '0;
		endcase
		return e;
	endfunction

	// parameter byte count, limited to MAX_PARAM_BYTES
	function automatic logic [POS_W-1:0] entry_nargs(input logic [ENTRY_W-1:0] idx);
		seq_entry_t e;
		logic [2:0] n;
		e = seq_entry(idx);
		n = e.nargs;
		if (int'(n) > MAX_PARAM_BYTES)
			n = 3'(MAX_PARAM_BYTES);
		return POS_W'(n);
	endfunction

endpackage
`default_nettype wire

FILE: src/lcdpi_front.sv
// Front end: configuration registers, sequencer state and per-step classification.
`default_nettype none
module lcdpi_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_idx,
	input  wire logic [15:0]         cfg_wdata,
	input  wire logic                take,
	input  wire lcdpi_pkg::in_item_t item,
	output lcdpi_pkg::job_t          job
);

	lcdpi_pkg::cfg_t                        cfg_q;
	lcdpi_pkg::phase_t                      phase_q, phase_d;
	logic [lcdpi_pkg::CMD_IDX_W-1:0]        cmd_idx_q, cmd_idx_d;
	logic [31:0]                            deadline_q, deadline_d;
	logic                                   rst_line_q, rst_line_d;
	logic                                   ready_q, ready_d;
	logic                                   waiting;
	lcdpi_pkg::seq_entry_t                  cur;
	logic [lcdpi_pkg::ENTRY_W-1:0]          cur_idx;
	logic [31:0]                            elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ms     <= lcdpi_pkg::RESET_LOW_DEFAULT;
			cfg_q.reset_recover_ms <= lcdpi_pkg::RESET_RECOVER_DEFAULT;
		end else if (cfg_we) begin
			case (cfg_idx)
				lcdpi_pkg::CFG_RESET_LOW:     cfg_q.reset_low_ms <= cfg_wdata;
				lcdpi_pkg::CFG_RESET_RECOVER: cfg_q.reset_recover_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lcdpi_pkg::PH_IDLE;
			cmd_idx_q  <= '0;
			deadline_q <= '0;
			rst_line_q <= 1'b1;
			ready_q    <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			cmd_idx_q  <= cmd_idx_d;
			deadline_q <= deadline_d;
			rst_line_q <= rst_line_d;
			ready_q    <= ready_d;
		end
	end

	assign elapsed = item.now_ms - deadline_q;
	assign waiting = elapsed[31];
	assign cur_idx = lcdpi_pkg::ENTRY_W'(cmd_idx_q);
	assign cur     = lcdpi_pkg::seq_entry(cur_idx);

	always_comb begin
		phase_d    = phase_q;
		cmd_idx_d  = cmd_idx_q;
		deadline_d = deadline_q;
		rst_line_d = rst_line_q;
		ready_d    = ready_q;
		job        = '0;
		job.status = lcdpi_pkg::STATUS_OK;
		if (item.action) begin
			phase_d    = lcdpi_pkg::PH_RST_LOW;
			cmd_idx_d  = '0;
			deadline_d = item.now_ms + 32'(cfg_q.reset_low_ms);
			ready_d    = 1'b0;
			rst_line_d = 1'b0;
		end else if (phase_q == lcdpi_pkg::PH_READY || waiting) begin
			// hold: sequence done, or nothing due yet
		end else begin
			case (phase_q)
				lcdpi_pkg::PH_RST_LOW: begin
					rst_line_d = 1'b1;
					deadline_d = item.now_ms + 32'(cfg_q.reset_recover_ms);
					phase_d    = lcdpi_pkg::PH_RST_HIGH;
				end
				lcdpi_pkg::PH_RST_HIGH: begin
					phase_d = lcdpi_pkg::PH_CMDS;
				end
				lcdpi_pkg::PH_CMDS: begin
					if (cmd_idx_q >= lcdpi_pkg::CMD_IDX_W'(lcdpi_pkg::NUM_INIT_COMMANDS)) begin
						ready_d = 1'b1;
						phase_d = lcdpi_pkg::PH_READY;
					end else if (item.bus_fault) begin
						phase_d    = lcdpi_pkg::PH_ERROR;
						job.status = lcdpi_pkg::STATUS_FAULT;
					end else begin
						job.has_entry = 1'b1;
						job.entry     = cur_idx;
						deadline_d    = item.now_ms + 32'(cur.wait_ms);
						cmd_idx_d     = cmd_idx_q + 1'b1;
					end
				end
				default: job.status = lcdpi_pkg::STATUS_IDLE;
			endcase
		end
		job.reset_level = rst_line_d;
		job.ready_flag  = ready_d;
	end

endmodule
`default_nettype wire

FILE: src/lcdpi_queue.sv
// Short job queue between the front end and the byte emitter.
`default_nettype none
module lcdpi_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lcdpi_pkg::job_t push_job,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output lcdpi_pkg::job_t      head
);

	lcdpi_pkg::job_t                  mem_q [lcdpi_pkg::QUEUE_DEPTH];
	logic [lcdpi_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [lcdpi_pkg::QCNT_W-1:0]     count_q;
	logic                             do_pop;

	assign full       = count_q == lcdpi_pkg::QCNT_W'(lcdpi_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/lcdpi_back.sv
// Back end: expands queued jobs into registered output words, one per unstalled cycle.
`default_nettype none
module lcdpi_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire lcdpi_pkg::job_t      head,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output lcdpi_pkg::out_item_t      out_item
);

	logic [lcdpi_pkg::POS_W-1:0]      pos_q;
	logic [lcdpi_pkg::POS_W-1:0]      n_args;
	logic [lcdpi_pkg::ARG_IDX_W-1:0]  arg_idx;
	lcdpi_pkg::seq_entry_t            ent;
	lcdpi_pkg::out_item_t             word;
	lcdpi_pkg::out_item_t             out_q;
	logic                             out_valid_q;
	logic                             load;

	assign ent     = lcdpi_pkg::seq_entry(head.entry);
	assign n_args  = lcdpi_pkg::entry_nargs(head.entry);
	assign arg_idx = lcdpi_pkg::ARG_IDX_W'(pos_q - 1'b1);
	assign load    = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		word             = '0;
		word.reset_level = head.reset_level;
		word.ready_flag  = head.ready_flag;
		word.step_status = head.status;
		if (!head.has_entry) begin
			word.last_of_run = 1'b1;
		end else if (pos_q == '0) begin
			word.byte_valid  = 1'b1;
			word.byte_value  = ent.op;
			word.last_of_run = n_args == '0;
		end else begin
			word.byte_valid  = 1'b1;
			word.byte_value  = ent.args[arg_idx];
			word.is_data     = 1'b1;
			word.last_of_run = pos_q == n_args;
		end
	end

	// drop the job once its final word is loaded
	assign pop = load && word.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				pos_q <= word.last_of_run ? '0 : pos_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= word;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

FILE: src/lcd_power_on_init_sequencer.sv
// Top level of the display power-on init sequencer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  in_item   (action, now_ms, bus_fault)
//   out      output     out_valid/out_ready  out_item  (one word per result)
//   cfg      input      cfg_we               cfg_idx, cfg_wdata
//
// A step is classified in the cycle it is accepted; a new step can be taken every
// cycle while the four-entry job queue has room.
// The emitter sends one word per cycle unless the output stalls: 1 word per step,
// 1 + parameter count for a table command; emitter and output set sustained rate.
// A stalled output holds its word; the queue absorbs up to four steps meanwhile.
// Reset returns the sequencer to idle with reset released and config at defaults.
`default_nettype none
module lcd_power_on_init_sequencer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire lcdpi_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output lcdpi_pkg::out_item_t      out_item,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_idx,
	input  wire logic [15:0]          cfg_wdata
);

	lcdpi_pkg::job_t  job;
	lcdpi_pkg::job_t  head;
	logic             full;
	logic             take;
	logic             head_valid;
	logic             pop;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	lcdpi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.take     (take),
		.item     (in_item),
		.job      (job)
	);

	lcdpi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_job  (job),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	lcdpi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

FILE: src/lcdpi_checker.sv
// Port-level checks of the init sequencer, bound to the top level.
`default_nettype none
module lcdpi_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire lcdpi_pkg::out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output word changed while stalled");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.byte_valid |->
			out_item.byte_value == 8'h00 && !out_item.is_data && out_item.last_of_run)
		else $error("empty word carries byte fields or is not last");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.step_status != lcdpi_pkg::STATUS_OK |->
			!out_item.byte_valid && out_item.last_of_run)
		else $error("error status word carries a byte");

	a_ready_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.ready_flag |-> out_item.reset_level)
		else $error("ready reported with display reset asserted");

	a_data_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.byte_valid && !out_item.last_of_run |=>
			!out_valid || (out_item.byte_valid && out_item.is_data))
		else $error("command not followed by its parameter word");

endmodule

bind lcd_power_on_init_sequencer lcdpi_checker u_lcdpi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
`default_nettype wire
